// File: rtl/size_class_block_allocator_assert.svh
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_ASSERT_SVH
// Assertion helpers clocked on clk with the asynchronous reset as disable.
`define SCBA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SCBA_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`endif

// File: rtl/scba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package scba_pkg;
	localparam int unsigned NumClassesMax = 7;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_TOO_LARGE  = 2'd1,
		ST_EXHAUSTED  = 2'd2,
		ST_GLOBAL_FULL = 2'd3
	} status_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_kind_t;

	typedef enum logic {
		CFG_REGION_BASE  = 1'b0,
		CFG_REGION_LIMIT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic        req_type;
		logic [1:0]  worker_id;
		logic [19:0] req_size;
		logic [31:0] free_address;
	} req_t;

	typedef struct packed {
		logic [31:0] block_address;
		logic [1:0]  status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOK,
		S_POP_RD,
		S_POP_WAIT,
		S_REF_GL_RD,
		S_REF_GL_WAIT,
		S_REF_BUMP,
		S_SPILL_FIRST,
		S_SPILL_RD,
		S_SPILL_WAIT,
		S_RESP
	} state_t;

	// Local stack capacity per class before the LOCAL_DEPTH limit.
	function automatic logic [8:0] class_cap_raw(input logic [2:0] c);
		logic [8:0] r;
		begin
			case (c)
				3'd0: r = 9'd256;
				3'd1: r = 9'd128;
				3'd2: r = 9'd64;
				3'd3: r = 9'd64;
				3'd4: r = 9'd32;
				3'd5: r = 9'd16;
				3'd6: r = 9'd8;
				default: r = 9'd8;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

// File: rtl/scba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module scba_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/size_class_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// One request at a time; no new transaction is taken until the result has been taken.
// A refill takes blocks from the global stack or, once that is empty, from the bump pointer; a
// spill moves blocks from the local stack to the global one (up to 127). Each step that
// moves a block out of a stack waits for a registered stack read.
// Reset clears counters, bump pointer and configuration; stack contents stay undefined.
module size_class_block_allocator #(
	parameter int unsigned NUM_WORKERS  = 4,
	parameter int unsigned NUM_CLASSES  = 7,
	parameter int unsigned LOCAL_DEPTH  = 256,
	parameter int unsigned GLOBAL_DEPTH = 1024,
	parameter int unsigned CHUNK_BYTES  = 32768
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire scba_pkg::req_t  in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output scba_pkg::rsp_t       out_data,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic            cfg_index,
	input  wire logic [31:0]     cfg_data
);
	import scba_pkg::*;
`include "size_class_block_allocator_assert.svh"

	localparam int unsigned WB  = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
	localparam int unsigned LB  = $clog2(LOCAL_DEPTH);
	localparam int unsigned GB  = $clog2(GLOBAL_DEPTH);
	localparam int unsigned SLOTS = NUM_WORKERS * NUM_CLASSES;
	localparam int unsigned SB  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CB  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int unsigned LAB = $clog2(SLOTS * LOCAL_DEPTH);
	localparam int unsigned GAB = $clog2(NUM_CLASSES * GLOBAL_DEPTH);

	state_t state_q, state_d;

	logic [31:0]  region_base_q, region_limit_q;
	logic [31:0]  bump_next_q, bump_end_q, chunk_off_q;
	logic [LB:0]  lcnt_q [SLOTS];
	logic [GB:0]  gcnt_q [NUM_CLASSES];

	req_t         req_q;
	logic [2:0]   cls_q;
	logic [WB-1:0] wk_q;
	logic [SB-1:0] slot_q;
	logic [LB:0]  cap_q;
	logic [LB:0]  got_q;
	logic [31:0]  addr_q;
	logic [1:0]   status_q;

	// Class search: one 32-bit compare per class, done combinationally at LOOK.
	logic [2:0] cls_c;
	logic       big_c;
	always_comb begin
		cls_c = 3'(NUM_CLASSES);
		for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
			if ({12'd0, req_q.req_size} <= (32'd32 << i)) begin
				cls_c = 3'(i);
			end
		end
		big_c = (cls_c == 3'(NUM_CLASSES));
	end

	logic [LB:0] cap_c;
	always_comb begin
		cap_c = (class_cap_raw(cls_c) < 9'(LOCAL_DEPTH)) ? (LB+1)'(class_cap_raw(cls_c))
			: (LB+1)'(LOCAL_DEPTH);
	end

	logic [LB:0] half_q;
	assign half_q = cap_q >> 1;

	logic [LB:0] lcnt_cur;
	logic [GB:0] gcnt_cur;
	assign lcnt_cur = lcnt_q[slot_q];
	assign gcnt_cur = gcnt_q[cls_q[CB-1:0]];

	// Stack RAMs.
	logic          l_we, g_we;
	logic [LAB-1:0] l_waddr, l_raddr;
	logic [GAB-1:0] g_waddr, g_raddr;
	logic [31:0]   l_wdata, g_wdata, l_rdata, g_rdata;

	scba_ram #(.WIDTH(32), .DEPTH(SLOTS * LOCAL_DEPTH)) u_local (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata)
	);
	scba_ram #(.WIDTH(32), .DEPTH(NUM_CLASSES * GLOBAL_DEPTH)) u_global (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.raddr(g_raddr), .rdata(g_rdata)
	);

	logic [LAB-1:0] l_top;
	logic [GAB-1:0] g_top;
	assign l_top = LAB'(slot_q) * LAB'(LOCAL_DEPTH) + LAB'(lcnt_cur);
	assign g_top = GAB'(cls_q) * GAB'(GLOBAL_DEPTH) + GAB'(gcnt_cur);

	// Bump pointer arithmetic, one 33-bit add and compare each.
	logic [32:0] bsz, bump_sum, chunk_base, chunk_end;
	logic        need_chunk, chunk_fail;
	assign bsz        = 33'd32 << cls_q;
	assign bump_sum   = {1'b0, bump_next_q} + bsz;
	assign need_chunk = bump_sum > {1'b0, bump_end_q};
	assign chunk_base = {1'b0, region_base_q} + {1'b0, chunk_off_q};
	assign chunk_end  = chunk_base + 33'(CHUNK_BYTES);
	// A chunk that starts past the top of the address space never fits.
	assign chunk_fail = chunk_base[32] || (chunk_end > {1'b0, region_limit_q});

	logic rd_pending_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pending_q <= 1'b0;
		end else begin
			rd_pending_q <= (state_q == S_POP_RD) || (state_q == S_REF_GL_RD)
				|| (state_q == S_SPILL_RD);
		end
	end

	always_comb begin
		state_d = state_q;
		l_we = 1'b0; g_we = 1'b0;
		l_waddr = l_top; l_wdata = addr_q;
		l_raddr = l_top - LAB'(1);
		g_waddr = g_top; g_wdata = l_rdata;
		g_raddr = g_top - GAB'(1);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (big_c) begin
					state_d = S_RESP;
				end else if (req_q.req_type == REQ_ALLOC) begin
					state_d = (lcnt_q[SB'(32'(wk_q) * NUM_CLASSES + 32'(cls_c))] == '0)
						? S_REF_GL_RD : S_POP_RD;
				end else begin
					state_d = S_SPILL_FIRST;
				end
			end
			S_POP_RD: state_d = S_POP_WAIT;
			S_POP_WAIT: state_d = S_RESP;
			S_REF_GL_RD: begin
				if (got_q >= half_q) begin
					state_d = (lcnt_cur == '0) ? S_RESP : S_POP_RD;
				end else if (gcnt_cur != '0) begin
					state_d = S_REF_GL_WAIT;
				end else if (need_chunk && chunk_fail) begin
					state_d = (lcnt_cur == '0) ? S_RESP : S_POP_RD;
				end else begin
					state_d = S_REF_BUMP;
				end
			end
			S_REF_GL_WAIT: begin
				l_we = 1'b1;
				l_wdata = g_rdata;
				state_d = S_REF_GL_RD;
			end
			S_REF_BUMP: begin
				l_we = 1'b1;
				l_wdata = need_chunk ? chunk_base[31:0] : bump_next_q;
				state_d = S_REF_GL_RD;
			end
			S_SPILL_FIRST: begin
				if (lcnt_cur < cap_q) begin
					l_we = 1'b1;
					l_wdata = req_q.free_address;
					state_d = S_RESP;
				end else if ((GB+1)'(GLOBAL_DEPTH) - gcnt_cur < (GB+1)'(half_q)) begin
					state_d = S_RESP;
				end else begin
					g_we = 1'b1;
					g_wdata = req_q.free_address;
					state_d = S_SPILL_RD;
				end
			end
			S_SPILL_RD: begin
				if (got_q >= half_q || lcnt_cur == '0) begin
					state_d = S_RESP;
				end else begin
					state_d = S_SPILL_WAIT;
				end
			end
			S_SPILL_WAIT: begin
				g_we = 1'b1;
				g_wdata = l_rdata;
				state_d = S_SPILL_RD;
			end
			S_RESP: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q <= '0; region_limit_q <= '0;
			bump_next_q <= '0; bump_end_q <= '0; chunk_off_q <= '0;
			for (int i = 0; i < SLOTS; i++) lcnt_q[i] <= '0;
			for (int i = 0; i < NUM_CLASSES; i++) gcnt_q[i] <= '0;
			status_q <= ST_OK;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_REGION_BASE) region_base_q <= cfg_data;
				else region_limit_q <= cfg_data;
			end
			case (state_q)
				S_LOOK: begin
					status_q <= big_c ? ST_TOO_LARGE : ST_OK;
				end
				S_POP_RD: lcnt_q[slot_q] <= lcnt_cur - 1'b1;
				S_REF_GL_RD: begin
					if (got_q < half_q && gcnt_cur != '0) begin
						gcnt_q[cls_q[CB-1:0]] <= gcnt_cur - 1'b1;
					end else if (got_q < half_q && need_chunk && chunk_fail
							&& lcnt_cur == '0) begin
						status_q <= ST_EXHAUSTED;
					end else if (got_q >= half_q && lcnt_cur == '0) begin
						status_q <= ST_EXHAUSTED;
					end
				end
				S_REF_GL_WAIT: lcnt_q[slot_q] <= lcnt_cur + 1'b1;
				S_REF_BUMP: begin
					lcnt_q[slot_q] <= lcnt_cur + 1'b1;
					if (need_chunk) begin
						chunk_off_q <= chunk_off_q + 32'(CHUNK_BYTES);
						bump_end_q  <= chunk_end[31:0];
						bump_next_q <= chunk_base[31:0] + bsz[31:0];
					end else begin
						bump_next_q <= bump_sum[31:0];
					end
				end
				S_SPILL_FIRST: begin
					if (lcnt_cur < cap_q) begin
						lcnt_q[slot_q] <= lcnt_cur + 1'b1;
					end else if ((GB+1)'(GLOBAL_DEPTH) - gcnt_cur < (GB+1)'(half_q)) begin
						status_q <= ST_GLOBAL_FULL;
					end else begin
						gcnt_q[cls_q[CB-1:0]] <= gcnt_cur + 1'b1;
					end
				end
				S_SPILL_RD: begin
					if (!(got_q >= half_q || lcnt_cur == '0)) begin
						lcnt_q[slot_q] <= lcnt_cur - 1'b1;
					end
				end
				S_SPILL_WAIT: gcnt_q[cls_q[CB-1:0]] <= gcnt_cur + 1'b1;
				default: ;
			endcase
		end
	end

	// Request context and the refill or spill counter.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q <= in_data;
				wk_q  <= WB'(32'(in_data.worker_id) % NUM_WORKERS);
			end
			S_LOOK: begin
				cls_q  <= cls_c;
				cap_q  <= cap_c;
				slot_q <= SB'(32'(wk_q) * NUM_CLASSES + 32'(cls_c));
				got_q  <= (req_q.req_type == REQ_FREE) ? (LB+1)'(1) : '0;
				addr_q <= '0;
			end
			S_REF_GL_WAIT, S_REF_BUMP, S_SPILL_WAIT: got_q <= got_q + 1'b1;
			S_POP_WAIT: addr_q <= l_rdata;
			default: ;
		endcase
		if (state_q == S_REF_BUMP) begin
			addr_q <= need_chunk ? chunk_base[31:0] : bump_next_q;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_RESP);
	assign cfg_ready = (state_q == S_IDLE) && !in_valid;
	assign out_data.block_address = (status_q == ST_OK && req_q.req_type == REQ_ALLOC)
		? addr_q : 32'd0;
	assign out_data.status = status_q;

	`SCBA_ASSERT(a_one_side, !(in_ready && out_valid), "input and output open together")
	`SCBA_ASSERT_NEXT(a_read_lat, (state_q == S_POP_RD), (state_q == S_POP_WAIT && rd_pending_q),
		"pop read not followed by wait")
	`SCBA_ASSERT(a_no_double_we, !(l_we && g_we), "both stacks written in one cycle")
	`SCBA_ASSERT_NEXT(a_resp_hold, (out_valid && !out_ready), out_valid,
		"result dropped before it was taken")
endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import scba_pkg::*;

	localparam int NWORK = 4;
	localparam int NCLS = 7;
	localparam int LDEPTH = 256;
	localparam int GDEPTH = 1024;
	localparam int CHUNK = 32768;
	localparam int STALL_LIMIT = 20000;

	// Tracks the allocator state and the responses it must produce, in order.
	class alloc_scoreboard;
		logic [31:0] local_stk[NWORK][NCLS][LDEPTH];
		int unsigned local_cnt[NWORK][NCLS];
		logic [31:0] global_stk[NCLS][GDEPTH];
		int unsigned global_cnt[NCLS];
		logic [31:0] bump_next, bump_end, chunk_offset;
		logic [31:0] region_base, region_limit;
		rsp_t expected_rsp[$];
		int errors;

		function new();
			foreach (local_cnt[w, c]) local_cnt[w][c] = 0;
			foreach (global_cnt[c]) global_cnt[c] = 0;
			bump_next = 0;
			bump_end = 0;
			chunk_offset = 0;
			region_base = 0;
			region_limit = 0;
			errors = 0;
		endfunction

		function void set_region(cfg_idx_t idx, logic [31:0] val);
			if (idx == CFG_REGION_BASE)
				region_base = val;
			else
				region_limit = val;
		endfunction

		function int unsigned cap_of(int unsigned c);
			int unsigned caps[NCLS] = '{256, 128, 64, 64, 32, 16, 8};
			return caps[c] < LDEPTH ? caps[c] : LDEPTH;
		endfunction

		// One block from the global stack, else from the bump pointer (new chunk if needed).
		function bit take_block(int unsigned c, output logic [31:0] addr);
			logic [32:0] bytes, start, stop;
			bytes = 33'd32 << c;
			addr = 0;
			if (global_cnt[c] > 0) begin
				global_cnt[c]--;
				addr = global_stk[c][global_cnt[c]];
				return 1;
			end
			if ({1'b0, bump_next} + bytes > {1'b0, bump_end}) begin
				start = {1'b0, region_base} + {1'b0, chunk_offset};
				stop = start + CHUNK;
				// A chunk that starts past the top of the address space never fits.
				if (start[32] || stop > {1'b0, region_limit})
					return 0;
				bump_next = start[31:0];
				bump_end = stop[31:0];
				chunk_offset = chunk_offset + CHUNK;
			end
			addr = bump_next;
			bump_next = bump_next + bytes[31:0];
			return 1;
		endfunction

		function void note_request(req_t rq);
			rsp_t r;
			int unsigned w, c, cap, half, i;
			logic [31:0] a;
			r.block_address = 0;
			r.status = ST_OK;
			w = rq.worker_id % NWORK;
			c = 0;
			while (c < NCLS && rq.req_size > (32 << c))
				c++;
			if (c >= NCLS) begin
				r.status = ST_TOO_LARGE;
			end else begin
				cap = cap_of(c);
				half = cap / 2;
				if (rq.req_type == REQ_ALLOC) begin
					if (local_cnt[w][c] == 0) begin
						for (i = 0; i < half; i++) begin
							if (!take_block(c, a))
								break;
							local_stk[w][c][local_cnt[w][c]] = a;
							local_cnt[w][c]++;
						end
					end
					if (local_cnt[w][c] == 0) begin
						r.status = ST_EXHAUSTED;
					end else begin
						local_cnt[w][c]--;
						r.block_address = local_stk[w][c][local_cnt[w][c]];
					end
				end else if (local_cnt[w][c] < cap) begin
					local_stk[w][c][local_cnt[w][c]] = rq.free_address;
					local_cnt[w][c]++;
				end else if (GDEPTH - global_cnt[c] < half) begin
					r.status = ST_GLOBAL_FULL;
				end else begin
					// The freed block goes first, then blocks from the top of the local stack.
					global_stk[c][global_cnt[c]] = rq.free_address;
					global_cnt[c]++;
					for (i = 1; i < half && local_cnt[w][c] > 0; i++) begin
						local_cnt[w][c]--;
						global_stk[c][global_cnt[c]] = local_stk[w][c][local_cnt[w][c]];
						global_cnt[c]++;
					end
				end
			end
			expected_rsp.push_back(r);
		endfunction

		function void check_response(rsp_t got);
			rsp_t exp;
			if (expected_rsp.size() == 0) begin
				$error("response with nothing outstanding: address %h status %0d",
					got.block_address, got.status);
				errors++;
				return;
			end
			exp = expected_rsp.pop_front();
			if (got.block_address !== exp.block_address) begin
				$error("block_address: expected %h, got %h", exp.block_address, got.block_address);
				errors++;
			end
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	rsp_t out_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_index = 0;
	logic [31:0] cfg_data = 0;

	alloc_scoreboard sb = new();
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit hold_req = 0;
	bit rx_hold = 0;
	int quiet_cycles = 0;
	logic [31:0] live_addr[$];
	logic [19:0] live_size[$];
	// Size of every accepted request, in order, so that freed blocks reuse a matching class.
	logic [19:0] last_alloc_size[$];

	size_class_block_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_request(in_data);
		if (cfg_valid && cfg_ready)
			sb.set_region(cfg_idx_t'(cfg_index), cfg_data);
		if (out_valid && out_ready) begin
			if (sb.expected_rsp.size() > 0 && sb.expected_rsp[0].status == ST_OK
					&& sb.expected_rsp[0].block_address == out_data.block_address
					&& out_data.block_address != 0) begin
				live_addr.push_back(out_data.block_address);
				live_size.push_back(last_alloc_size.pop_front());
			end else if (last_alloc_size.size() > 0 && sb.expected_rsp.size() > 0) begin
				void'(last_alloc_size.pop_front());
			end
			sb.check_response(out_data);
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk)
		if (in_valid && in_ready)
			last_alloc_size.push_back(in_data.req_size);

	always @(negedge clk)
		out_ready = !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);

	initial begin
		forever begin
			wait (hold_req);
			rx_hold = 1;
			repeat (400) @(posedge clk);
			rx_hold = 0;
			hold_req = 0;
		end
	end

	task automatic send_req(input logic rtype, input logic [1:0] wid, input logic [19:0] sz,
			input logic [31:0] addr);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct)
			@(negedge clk);
		in_data = {rtype, wid, sz, addr};
		in_valid = 1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic drain();
		while (sb.expected_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic random_req();
		int pick, c, k;
		logic [19:0] sz;
		pick = $urandom_range(0, 99);
		c = $urandom_range(0, 6);
		sz = 20'($urandom_range(c == 0 ? 0 : (16 << c) + 1, 32 << c));
		if (pick < 45) begin
			send_req(REQ_ALLOC, 2'($urandom_range(0, 3)), sz, $urandom);
		end else if (pick < 85 && live_addr.size() > 0) begin
			k = $urandom_range(0, live_addr.size() - 1);
			send_req(REQ_FREE, 2'($urandom_range(0, 3)), live_size[k], live_addr[k]);
			live_addr.delete(k);
			live_size.delete(k);
		end else if (pick < 92) begin
			send_req(REQ_FREE, 2'($urandom_range(0, 3)), sz, $urandom);
		end else begin
			send_req(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
				20'($urandom_range(0, 20'hFFFFF)), $urandom);
		end
	endtask

	initial begin
		int i;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Empty region: allocations run dry unless a block was freed first; frees and oversized requests still work.
		send_req(REQ_ALLOC, 0, 0, 0);
		send_req(REQ_ALLOC, 3, 20'd2048, 0);
		send_req(REQ_ALLOC, 1, 20'd2049, 0);
		send_req(REQ_FREE, 2, 20'hFFFFF, 32'hFFFF_FFFF);
		send_req(REQ_FREE, 1, 20'd1, 32'h0);
		send_req(REQ_ALLOC, 1, 20'd1, 32'hFFFF_FFFF);
		send_req(REQ_ALLOC, 1, 20'd1, 0);
		drain();
		write_reg(CFG_REGION_BASE, 32'h1000_0000);
		write_reg(CFG_REGION_LIMIT, 32'h1010_0000);
		for (i = 0; i < NCLS; i++)
			send_req(REQ_ALLOC, 2'(i), 20'd32 << i, 0);
		send_req(REQ_ALLOC, 0, 20'd33, 0);
		send_req(REQ_ALLOC, 2, 20'd1025, 0);
		send_req(REQ_FREE, 3, 20'd2048, 32'h1234_5678);
		send_req(REQ_ALLOC, 3, 20'd2000, 0);
		for (i = 0; i < 9; i++)
			send_req(REQ_FREE, 1, 20'd2048, $urandom);
		drain();

		tx_idle_pct = 36;
		rx_idle_pct = 70;
		hold_req = 1;
		for (i = 0; i < 100; i++)
			random_req();
		drain();

		// Near the top of the address space the chunk end runs past the region limit.
		write_reg(CFG_REGION_BASE, 32'hFFFF_0000);
		write_reg(CFG_REGION_LIMIT, 32'hFFFF_FFFF);
		tx_idle_pct = 70;
		rx_idle_pct = 36;
		for (i = 0; i < 100; i++)
			random_req();
		drain();

		write_reg(CFG_REGION_BASE, 32'h0);
		write_reg(CFG_REGION_LIMIT, 32'hFFFF_FFFF);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		// Enough frees of the largest class to fill its global stack.
		for (i = 0; i < 1060; i++)
			send_req(REQ_FREE, 2'($urandom_range(0, 3)), 20'($urandom_range(1025, 2048)),
				$urandom);
		for (i = 0; i < 20; i++)
			random_req();
		drain();

		if (sb.errors == 0 && sb.expected_rsp.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// File: sim.f
+incdir+rtl
rtl/scba_pkg.sv
rtl/scba_ram.sv
rtl/size_class_block_allocator.sv
test/testbench.sv
